@@ hw/rtl/mcqc_pkg.sv @@
// Shared types, constants and generator step for the quarter-circle hit counter.
package mcqc_pkg;

  localparam int COUNT_BITS = 20;
  localparam int RAND_BITS  = 17;
  localparam int MUL_BITS   = 11;
  localparam int SQ_BITS    = 2 * RAND_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  localparam logic [MUL_BITS-1:0]  LCG_MUL = MUL_BITS'(1277);
  localparam logic [RAND_BITS-1:0] LCG_ADD = RAND_BITS'(1);
  localparam logic [RAND_BITS-1:0] RADIUS  = RAND_BITS'(131071);
  localparam logic [SUM_BITS-1:0]  HIT_LIMIT = SUM_BITS'(RADIUS) * SUM_BITS'(RADIUS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef logic [RAND_BITS-1:0]  rand_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW_X,
    ST_DRAW_Y,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic draw;
    logic draw_y;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic slot_free;
  } dp_status_t;

  // One generator step: (1277*u + 1) mod 2^17, keep the low bits.
  function automatic rand_t lcg_next(input rand_t u);
    logic [RAND_BITS+MUL_BITS-1:0] prod;
    prod = (RAND_BITS+MUL_BITS)'(LCG_MUL) * (RAND_BITS+MUL_BITS)'(u);
    return prod[RAND_BITS-1:0] + LCG_ADD;
  endfunction

endpackage

@@ hw/rtl/mcqc_if.sv @@
// Valid/ready channel interfaces for commands and results.
interface mcqc_in_if;
  import mcqc_pkg::*;
  logic   valid;
  logic   ready;
  logic   command;
  rand_t  seed_value;
  count_t point_count;

  modport source (output valid, output command, output seed_value, output point_count,
                  input ready);
  modport sink   (input valid, input command, input seed_value, input point_count,
                  output ready);
endinterface

interface mcqc_out_if;
  import mcqc_pkg::*;
  logic   valid;
  logic   ready;
  count_t hit_count;
  rand_t  final_random;

  modport source (output valid, output hit_count, output final_random, input ready);
  modport sink   (input valid, input hit_count, input final_random, output ready);
endinterface

@@ hw/rtl/mcqc_ctrl.sv @@
// Sequencer: accepts words, walks the point count and triggers the result.
module mcqc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  input  mcqc_pkg::count_t     in_point_count,
  output logic                 in_ready,
  input  mcqc_pkg::dp_status_t status,
  output mcqc_pkg::dp_cmd_t    cmd
);
  import mcqc_pkg::*;

  state_t state_r, state_nxt;
  count_t remain_r, remain_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Next state and point counter.
  always_comb begin
    state_nxt  = state_r;
    remain_nxt = remain_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_RUN) begin
          remain_nxt = in_point_count;
          state_nxt  = (in_point_count == '0) ? ST_DRAIN : ST_DRAW_X;
        end
      end
      ST_DRAW_X: state_nxt = ST_DRAW_Y;
      ST_DRAW_Y: begin
        remain_nxt = remain_r - COUNT_BITS'(1);
        state_nxt  = (remain_r == COUNT_BITS'(1)) ? ST_DRAIN : ST_DRAW_X;
      end
      ST_DRAIN: begin
        if (!status.busy && status.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && in_command == CMD_LOAD;
        cmd.clear = in_valid && in_command == CMD_RUN;
      end
      ST_DRAW_X: cmd.draw = 1'b1;
      ST_DRAW_Y: begin
        cmd.draw   = 1'b1;
        cmd.draw_y = 1'b1;
      end
      ST_DRAIN: cmd.publish = !status.busy && status.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/mcqc_dpath.sv @@
// Datapath: generator, squaring pipeline, hit counter and result register.
module mcqc_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mcqc_pkg::dp_cmd_t    cmd,
  input  mcqc_pkg::rand_t      seed_value,
  output mcqc_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcqc_pkg::count_t     out_hit_count,
  output mcqc_pkg::rand_t      out_final_random
);
  import mcqc_pkg::*;

  rand_t                u_r;
  logic [SQ_BITS-1:0]   xsq_r, ysq_r;
  logic                 sq_pend_r, cmp_pend_r;
  count_t               hits_r;
  logic                 out_valid_r;
  count_t               out_hits_r;
  rand_t                out_rand_r;
  logic [SUM_BITS-1:0]  sum;

  assign sum = SUM_BITS'(xsq_r) + SUM_BITS'(ysq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r         <= '0;
      sq_pend_r   <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        u_r <= seed_value;
      end else if (cmd.draw) begin
        u_r <= lcg_next(u_r);
      end
      // y is in u_r the cycle after its draw: square it then, compare after
      sq_pend_r  <= cmd.draw_y;
      cmp_pend_r <= sq_pend_r;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_y) xsq_r <= SQ_BITS'(u_r) * SQ_BITS'(u_r);
    if (sq_pend_r)  ysq_r <= SQ_BITS'(u_r) * SQ_BITS'(u_r);
    if (cmd.clear) begin
      hits_r <= '0;
    end else if (cmp_pend_r && sum <= HIT_LIMIT) begin
      hits_r <= hits_r + COUNT_BITS'(1);
    end
    if (cmd.publish) begin
      out_hits_r <= hits_r;
      out_rand_r <= u_r;
    end
  end

  assign status.busy      = sq_pend_r || cmp_pend_r;
  assign status.slot_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_hit_count    = out_hits_r;
  assign out_final_random = out_rand_r;

endmodule

@@ hw/rtl/monte_carlo_quarter_circle_hits_top.sv @@
// Top level of the Monte Carlo quarter-circle hit counter.
//
//   channel  dir  payload                                 handshake
//   in_ch    in   command, seed_value, point_count        valid/ready
//   out_ch   out  hit_count, final_random                 valid/ready
//
// A run word of N points has the generator draw 2*N values, one value per
// cycle, and a squaring stage plus a compare stage drain after the last draw.
// A run of zero points goes straight to publishing its result.
// Reset clears the generator to zero and empties the result register.
// A waiting result does not block the next word; a finished run holds until
// the result register is free.
module monte_carlo_quarter_circle_hits_top (
  input  logic clk,
  input  logic rst_n,
  mcqc_in_if.sink    in_ch,
  mcqc_out_if.source out_ch
);
  import mcqc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mcqc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_command     (in_ch.command),
    .in_point_count (in_ch.point_count),
    .in_ready       (in_ch.ready),
    .status         (status),
    .cmd            (cmd)
  );

  mcqc_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .seed_value       (in_ch.seed_value),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_hit_count    (out_ch.hit_count),
    .out_final_random (out_ch.final_random)
  );

endmodule

@@ hw/rtl/mcqc_checker.sv @@
// Port-level assertions for the hit counter, bound to the top level.
module mcqc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_command,
  input logic             out_valid,
  input logic             out_ready,
  input mcqc_pkg::count_t out_hit_count,
  input mcqc_pkg::rand_t  out_final_random
);
  import mcqc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit_count) && $stable(out_final_random))
    else $error("result payload changed while stalled");

  // A run keeps the input closed at least for the cycle after it is taken.
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_RUN |=> !in_ready)
    else $error("input ready right after a run word");

  // A result never shows up on the edge right after a word is taken.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared without run latency");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind monte_carlo_quarter_circle_hits_top mcqc_checker u_mcqc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_command       (in_ch.command),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_hit_count    (out_ch.hit_count),
  .out_final_random (out_ch.final_random)
);

@@ bench/hit_count_checker.sv @@
// Watches both channels, predicts each run's hit tally and compares it with the block's result.
module hit_count_checker (
  input  logic clk,
  input  logic rst_n,
  mcqc_in_if   in_mon,
  mcqc_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mcqc_pkg::*;

  localparam logic [35:0] RADIUS_SQ = 36'd131071 * 36'd131071;
  localparam rand_t       GEN_MUL   = rand_t'(1277);
  localparam rand_t       GEN_INC   = rand_t'(1);

  typedef struct packed {
    count_t hits;
    rand_t  last;
  } tally_t;

  rand_t  gen_state;
  tally_t expected_tallies[$];

  // The modulus is 2^17, so plain 17-bit wraparound does the reduction.
  function automatic rand_t gen_next(input rand_t u);
    return u * GEN_MUL + GEN_INC;
  endfunction

  function automatic tally_t run_points(input rand_t start, input count_t points);
    rand_t       u;
    logic [35:0] xx;
    logic [35:0] yy;
    tally_t      t;
    u = start;
    t.hits = '0;
    for (int unsigned i = 0; i < points; i++) begin
      u = gen_next(u);
      xx = 36'(u);
      u = gen_next(u);
      yy = 36'(u);
      if (xx * xx + yy * yy <= RADIUS_SQ) t.hits = t.hits + 1'b1;
    end
    t.last = u;
    return t;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      gen_state = '0;
      expected_tallies.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tallies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: hit_count=%0d final_random=%0d",
                     out_mon.hit_count, out_mon.final_random);
        end else begin
          want = expected_tallies.pop_front();
          if (out_mon.hit_count !== want.hits || out_mon.final_random !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected hit_count=%0d final_random=%0d, got hit_count=%0d final_random=%0d",
                       want.hits, want.last, out_mon.hit_count, out_mon.final_random);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD) begin
          gen_state = in_mon.seed_value;
        end else begin
          want = run_points(gen_state, in_mon.point_count);
          gen_state = want.last;
          expected_tallies.push_back(want);
        end
      end
    end
    pending <= expected_tallies.size();
  end

endmodule

@@ bench/monte_carlo_quarter_circle_hits_top_test.sv @@
// Stimulus, flow control and verdict for the quarter-circle hit counter.
module monte_carlo_quarter_circle_hits_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcqc_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_requests = 0;
  int   hold_served;
  int   hold_left;

  mcqc_in_if  in_ch ();
  mcqc_out_if out_ch ();

  monte_carlo_quarter_circle_hits_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_count_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The timeout must cover the longest run, the one of 2^20 - 1 points.
  initial begin
    #40_000_000;
    $display("monte_carlo_quarter_circle_hits_top_test NOT OK");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Call at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic cmd, input rand_t seed, input count_t points);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.seed_value  <= seed;
    in_ch.point_count <= points;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Keep most runs short; a few reach typical lengths.
  function automatic count_t pick_point_count();
    int r;
    r = $urandom_range(99, 0);
    if (r < 2)  return '0;
    if (r < 85) return count_t'($urandom_range(64, 1));
    if (r < 97) return count_t'($urandom_range(1024, 65));
    return count_t'($urandom_range(4096, 1025));
  endfunction

  task automatic send_random_word();
    if ($urandom_range(99, 0) < 20)
      send_word(CMD_LOAD, rand_t'($urandom), count_t'($urandom));
    else
      send_word(CMD_RUN, rand_t'($urandom), pick_point_count());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.seed_value = '0;
    in_ch.point_count = '0;
    send_idle_pct = 28;
    recv_idle_pct = 84;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, ignored fields, zero-point runs.
    send_word(CMD_RUN,  '0, count_t'(1));
    send_word(CMD_RUN,  '1, '0);
    send_word(CMD_LOAD, '1, '1);
    send_word(CMD_RUN,  '0, count_t'(2));
    send_word(CMD_LOAD, '0, count_t'('h55555));
    send_word(CMD_RUN,  rand_t'('h0AAAA), '0);
    send_word(CMD_LOAD, rand_t'('h15555), count_t'('hAAAAA));
    send_word(CMD_RUN,  '1, count_t'(3));
    send_word(CMD_LOAD, rand_t'('h0AAAA), '0);
    send_word(CMD_RUN,  rand_t'('h15555), count_t'(64));
    send_word(CMD_RUN,  rand_t'($urandom), '1);
    send_word(CMD_RUN,  '0, count_t'(7));
    send_word(CMD_LOAD, '0, count_t'(1));
    send_word(CMD_RUN,  '0, '0);
    send_word(CMD_RUN,  '0, count_t'(1));

    repeat (47) send_random_word();

    send_idle_pct = 84;
    recv_idle_pct = 28;
    repeat (47) send_random_word();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Hold the result side while short runs keep coming, so the input backs up.
    hold_requests++;
    repeat (10) send_word(CMD_RUN, rand_t'($urandom), count_t'($urandom_range(16, 1)));
    repeat (21) send_random_word();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("monte_carlo_quarter_circle_hits_top_test OK");
    else
      $display("monte_carlo_quarter_circle_hits_top_test NOT OK");
    $finish;
  end

endmodule
